// ===== hw/rtl/qte_pkg.sv =====
// shared widths, constants and the cordic angle table for the quaternion to euler unit
package qte_pkg;

  localparam int QW        = 16;  // quaternion component width, q1.14
  localparam int PROD_W    = 32;  // one component product
  localparam int SUM_W     = 34;  // sums of products in 2^-28 units
  localparam int RAD_W     = 57;  // radicand 2^56 - sinp^2
  localparam int ISQ_W     = 58;  // root remainder and partial root
  localparam int ISQ_STEPS = 29;  // one root bit per stage
  localparam int ROOT_W    = 29;  // final root, at most 2^28
  localparam int CW        = 38;  // cordic vector width
  localparam int ZW        = 29;  // cordic angle accumulator, q.24 radians
  localparam int ANG_W     = 16;  // output angle width, q2.13
  localparam int MAX_STEPS = 24;  // length of the arctangent table
  localparam int FRONT_STAGES = 3;

  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [CW-1:0]    vec_t;
  typedef logic signed [ZW-1:0]    ang_t;

  localparam sum_t ONE_Q28 = sum_t'(64'sd268435456);
  localparam ang_t PI_Q24  = ang_t'(64'sd52707179);

  // atan(2^-i) in q.24, rounded to nearest
  function automatic ang_t atan_entry(input int idx);
    ang_t r;
    case (idx)
      0:  r = ang_t'(13176795);
      1:  r = ang_t'(7778716);
      2:  r = ang_t'(4110060);
      3:  r = ang_t'(2086331);
      4:  r = ang_t'(1047214);
      5:  r = ang_t'(524117);
      6:  r = ang_t'(262123);
      7:  r = ang_t'(131069);
      8:  r = ang_t'(65536);
      9:  r = ang_t'(32768);
      10: r = ang_t'(16384);
      11: r = ang_t'(8192);
      12: r = ang_t'(4096);
      13: r = ang_t'(2048);
      14: r = ang_t'(1024);
      15: r = ang_t'(512);
      16: r = ang_t'(256);
      17: r = ang_t'(128);
      18: r = ang_t'(64);
      19: r = ang_t'(32);
      20: r = ang_t'(16);
      21: r = ang_t'(8);
      22: r = ang_t'(4);
      23: r = ang_t'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/quaternion_to_euler_angles_unit.sv =====
// top level: quaternion to euler angles, fully pipelined with per-stage flow control
//
// Takes one unit quaternion (w, x, y, z, q1.14) per cycle unless a stalled output has
// filled the pipeline, and returns pitch (x axis), yaw (y axis) and roll (z axis) angles
// in q2.13 radians. The pipeline is made of the 3 product and sum stages, the 29-stage
// bit-per-stage square root that feeds the asin path, and min(CORDIC_STEPS, 24) cordic
// micro-rotation stages with their quadrant and rounding stages.
// Each stage holds its own valid bit, so a stalled output lets upstream bubbles
// fill before the input stalls. When |2(wy-zx)| reaches one, yaw saturates to plus
// or minus half pi and yaw_clamped is set.
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pitch_angle [15:0], yaw_angle [30:16], roll_angle [46:31], yaw_clamped [47]
  output logic [47:0] m_axis_tdata
);
  import qte_pkg::*;

  localparam int N      = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int C_BASE = FRONT_STAGES + ISQ_STEPS;
  localparam int NST    = C_BASE + N + 2;
  localparam int SIDE_W = 5 * SUM_W + 2;

  logic [NST-1:0] v_q, en;
  sum_t sinr, cosr, siny, cosy, sinp;
  sum_t sinr_r, cosr_r, siny_r, cosy_r, sinp_r;
  logic [RAD_W-1:0] rad;
  logic clamp, pos, clamp_r, pos_r;
  logic [ROOT_W-1:0] root;
  logic [SIDE_W-1:0] side_r;
  logic [1:0] yaw_side;
  logic pitch_side, roll_side;
  logic signed [ANG_W-1:0] pitch_ang, yaw_ang, roll_ang;
  logic [ANG_W-2:0] yaw_out;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? s_axis_tvalid : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NST-1];

  // products and sums
  qte_front u_front (
    .clk_i    (clk_i),
    .en_i     (en[FRONT_STAGES-1:0]),
    .quat_w_i (s_axis_tdata[15:0]),
    .quat_x_i (s_axis_tdata[31:16]),
    .quat_y_i (s_axis_tdata[47:32]),
    .quat_z_i (s_axis_tdata[63:48]),
    .sinr_o   (sinr),
    .cosr_o   (cosr),
    .siny_o   (siny),
    .cosy_o   (cosy),
    .sinp_o   (sinp),
    .rad_o    (rad),
    .clamp_o  (clamp),
    .pos_o    (pos)
  );

  // asin cosine leg, other terms ride alongside
  qte_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[C_BASE-1:FRONT_STAGES]),
    .rad_i  (rad),
    .side_i ({pos, clamp, sinp, cosy, siny, cosr, sinr}),
    .root_o (root),
    .side_o (side_r)
  );

  assign {pos_r, clamp_r, sinp_r, cosy_r, siny_r, cosr_r, sinr_r} = side_r;

  // three atan2 pipelines in lockstep
  qte_cordic #(
    .STEPS  (N),
    .LIM    (PI_Q13),
    .SIDE_W (1)
  ) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en[NST-1:C_BASE]),
    .y_i     (vec_t'(sinr_r)),
    .x_i     (vec_t'(cosr_r)),
    .side_i  (1'b0),
    .angle_o (pitch_ang),
    .side_o  (pitch_side)
  );

  qte_cordic #(
    .STEPS  (N),
    .LIM    (HALF_PI_Q13),
    .SIDE_W (2)
  ) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en[NST-1:C_BASE]),
    .y_i     (vec_t'(sinp_r)),
    .x_i     (vec_t'({{(CW-ROOT_W){1'b0}}, root})),
    .side_i  ({pos_r, clamp_r}),
    .angle_o (yaw_ang),
    .side_o  (yaw_side)
  );

  qte_cordic #(
    .STEPS  (N),
    .LIM    (PI_Q13),
    .SIDE_W (1)
  ) u_roll (
    .clk_i   (clk_i),
    .en_i    (en[NST-1:C_BASE]),
    .y_i     (vec_t'(siny_r)),
    .x_i     (vec_t'(cosy_r)),
    .side_i  (pitch_side ^ pitch_side),
    .angle_o (roll_ang),
    .side_o  (roll_side)
  );

  // saturated yaw replaces the cordic result
  always_comb begin
    if (yaw_side[0]) begin
      yaw_out = yaw_side[1] ? (ANG_W-1)'(HALF_PI_Q13) : (ANG_W-1)'(-HALF_PI_Q13);
    end else begin
      yaw_out = yaw_ang[ANG_W-2:0];
    end
  end

  assign m_axis_tdata = {yaw_side[0] | (roll_side & 1'b0), roll_ang, yaw_out, pitch_ang};

endmodule

// ===== hw/rtl/qte_front.sv =====
// products, sums of products and the asin radicand, three register stages
module qte_front (
  input  logic                        clk_i,
  input  logic [qte_pkg::FRONT_STAGES-1:0] en_i,
  input  logic signed [qte_pkg::QW-1:0]    quat_w_i,
  input  logic signed [qte_pkg::QW-1:0]    quat_x_i,
  input  logic signed [qte_pkg::QW-1:0]    quat_y_i,
  input  logic signed [qte_pkg::QW-1:0]    quat_z_i,
  output qte_pkg::sum_t               sinr_o,
  output qte_pkg::sum_t               cosr_o,
  output qte_pkg::sum_t               siny_o,
  output qte_pkg::sum_t               cosy_o,
  output qte_pkg::sum_t               sinp_o,
  output logic [qte_pkg::RAD_W-1:0]   rad_o,
  output logic                        clamp_o,
  output logic                        pos_o
);
  import qte_pkg::*;

  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  sum_t sinr1_q, cosr1_q, siny1_q, cosy1_q, sinp1_q;
  sum_t sinr2_q, cosr2_q, siny2_q, cosy2_q, sinp2_q;
  logic [RAD_W-1:0] rad_q;
  logic clamp_q, pos_q;
  logic [ROOT_W-1:0] abs_p;
  logic [2*ROOT_W-1:0] sq;

  // stage 0: component products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // stage 1: doubled sums
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sinr1_q <= (sum_t'(wx_q) + sum_t'(yz_q)) <<< 1;
      cosr1_q <= ONE_Q28 - ((sum_t'(xx_q) + sum_t'(yy_q)) <<< 1);
      sinp1_q <= (sum_t'(wy_q) - sum_t'(zx_q)) <<< 1;
      siny1_q <= (sum_t'(wz_q) + sum_t'(xy_q)) <<< 1;
      cosy1_q <= ONE_Q28 - ((sum_t'(yy_q) + sum_t'(zz_q)) <<< 1);
    end
  end

  // stage 2: radicand 2^56 - sinp^2 and saturation check
  always_comb begin
    abs_p = sinp1_q[SUM_W-1] ? ROOT_W'(-sinp1_q) : ROOT_W'(sinp1_q);
    sq    = abs_p * abs_p;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sinr2_q <= sinr1_q;
      cosr2_q <= cosr1_q;
      siny2_q <= siny1_q;
      cosy2_q <= cosy1_q;
      sinp2_q <= sinp1_q;
      rad_q   <= (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(sq);
      clamp_q <= (sinp1_q >= ONE_Q28) || (sinp1_q <= -ONE_Q28);
      pos_q   <= (sinp1_q > 0);
    end
  end

  assign sinr_o  = sinr2_q;
  assign cosr_o  = cosr2_q;
  assign siny_o  = siny2_q;
  assign cosy_o  = cosy2_q;
  assign sinp_o  = sinp2_q;
  assign rad_o   = rad_q;
  assign clamp_o = clamp_q;
  assign pos_o   = pos_q;

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
// pipelined integer square root, one result bit per stage, with a side payload
module qte_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                             clk_i,
  input  logic [qte_pkg::ISQ_STEPS-1:0]    en_i,
  input  logic [qte_pkg::RAD_W-1:0]        rad_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic [qte_pkg::ROOT_W-1:0]       root_o,
  output logic [SIDE_W-1:0]                side_o
);
  import qte_pkg::*;

  logic [ISQ_W-1:0]  rem_q  [ISQ_STEPS];
  logic [ISQ_W-1:0]  res_q  [ISQ_STEPS];
  logic [SIDE_W-1:0] side_q [ISQ_STEPS];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_stage
    localparam int SH = 2 * (ISQ_STEPS - 1 - k);
    logic [ISQ_W-1:0] rem_p, res_p, trial, rem_d, res_d;
    logic [SIDE_W-1:0] side_p;

    if (k == 0) begin : g_first
      assign rem_p  = ISQ_W'(rad_i);
      assign res_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign res_p  = res_q[k-1];
      assign side_p = side_q[k-1];
    end

    // try to set this root bit
    always_comb begin
      trial = res_p + (ISQ_W'(1) << SH);
      if (rem_p >= trial) begin
        rem_d = rem_p - trial;
        res_d = (res_p >> 1) + (ISQ_W'(1) << SH);
      end else begin
        rem_d = rem_p;
        res_d = res_p >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign root_o = res_q[ISQ_STEPS-1][ROOT_W-1:0];
  assign side_o = side_q[ISQ_STEPS-1];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// pipelined cordic vectoring atan2: quadrant stage, micro-rotations, rounding stage
module qte_cordic #(
  parameter int STEPS  = 16,
  parameter int LIM    = 25736,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic [STEPS+1:0]              en_i,
  input  qte_pkg::vec_t                 y_i,
  input  qte_pkg::vec_t                 x_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic signed [qte_pkg::ANG_W-1:0] angle_o,
  output logic [SIDE_W-1:0]             side_o
);
  import qte_pkg::*;

  localparam logic signed [ZW-12:0] LIM_P = (ZW-11)'(LIM);

  vec_t x_q [STEPS+1];
  vec_t y_q [STEPS+1];
  ang_t z_q [STEPS+1];
  logic [SIDE_W-1:0] side_q [STEPS+1];
  logic signed [ANG_W-1:0] angle_q;
  logic [SIDE_W-1:0] side_out_q;
  ang_t zr;
  logic signed [ZW-12:0] r;

  // quadrant fold for negative x
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= side_i;
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar s = 1; s <= STEPS; s++) begin : g_rot
    localparam int I = s - 1;
    localparam ang_t ATAN = atan_entry(I);
    vec_t xs, ys;
    assign xs = x_q[s-1] >>> I;
    assign ys = y_q[s-1] >>> I;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        side_q[s] <= side_q[s-1];
        if (y_q[s-1] > 0) begin
          x_q[s] <= x_q[s-1] + ys;
          y_q[s] <= y_q[s-1] - xs;
          z_q[s] <= z_q[s-1] + ATAN;
        end else if (y_q[s-1] < 0) begin
          x_q[s] <= x_q[s-1] - ys;
          y_q[s] <= y_q[s-1] + xs;
          z_q[s] <= z_q[s-1] - ATAN;
        end else begin
          x_q[s] <= x_q[s-1];
          y_q[s] <= y_q[s-1];
          z_q[s] <= z_q[s-1];
        end
      end
    end
  end

  // round to q2.13 and saturate
  always_comb begin
    zr = z_q[STEPS] + ang_t'(1024);
    r  = zr[ZW-1:11];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[STEPS+1]) begin
      side_out_q <= side_q[STEPS];
      if (r > LIM_P) begin
        angle_q <= ANG_W'(LIM_P);
      end else if (r < -LIM_P) begin
        angle_q <= ANG_W'(-LIM_P);
      end else begin
        angle_q <= ANG_W'(r);
      end
    end
  end

  assign angle_o = angle_q;
  assign side_o  = side_out_q;

endmodule
